// ----- rtl/core/mie_pkg.sv -----
package mie_pkg;

    localparam int DATA_WIDTH = 32;
    // Bezout coefficients stay within plus or minus the modulus; two guard bits
    // keep the signed arithmetic exact.
    localparam int COEF_WIDTH = DATA_WIDTH + 2;
    localparam int CNT_WIDTH  = $clog2(DATA_WIDTH + 1);
    localparam int ADDR_WIDTH = 3;

    localparam logic [DATA_WIDTH-1:0] MODULUS_RESET = DATA_WIDTH'(1000000007);

    // Register index taken from paddr[2].
    localparam logic REG_MODULUS = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_FIN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ----- rtl/core/mie_div.sv -----
module mie_div
    import mie_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         go,
    input  logic [DATA_WIDTH-1:0]        dividend,
    input  logic [DATA_WIDTH-1:0]        divisor,
    input  logic signed [COEF_WIDTH-1:0] mult,
    output div_stat_t                    stat,
    output logic [DATA_WIDTH-1:0]        rem,
    output logic signed [COEF_WIDTH-1:0] prod
);

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [CNT_WIDTH-1:0]         cnt_reg, cnt_next;
    logic [DATA_WIDTH-1:0]        rem_reg, rem_next;
    logic [DATA_WIDTH-1:0]        dvd_reg, dvd_next;
    logic [DATA_WIDTH-1:0]        dvs_reg, dvs_next;
    logic signed [COEF_WIDTH-1:0] mul_reg, mul_next;
    logic signed [COEF_WIDTH-1:0] prod_reg, prod_next;

    logic [DATA_WIDTH:0]   shifted;
    logic [DATA_WIDTH+1:0] diff;
    logic                  qbit;

    // One restoring division step per cycle. The quotient bit also drives a
    // Horner accumulation of quotient times the multiplier.
    always_comb
    begin
        shifted = {rem_reg, dvd_reg[DATA_WIDTH-1]};
        diff    = {1'b0, shifted} - {2'b00, dvs_reg};
        qbit    = ~diff[DATA_WIDTH+1];

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        mul_next  = mul_reg;
        prod_next = prod_reg;

        if (go)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_WIDTH'(DATA_WIDTH);
            rem_next  = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
            mul_next  = mult;
            prod_next = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = qbit ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
            dvd_next  = {dvd_reg[DATA_WIDTH-2:0], 1'b0};
            prod_next = {prod_reg[COEF_WIDTH-2:0], 1'b0} + (qbit ? mul_reg : '0);
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_WIDTH'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        dvs_reg  <= dvs_next;
        mul_reg  <= mul_next;
        prod_reg <= prod_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign rem       = rem_reg;
    assign prod      = prod_reg;

endmodule

// ----- rtl/core/modular_inverse_ext_euclid.sv -----
// Modular inverse by the extended Euclidean algorithm. A request is taken when
// start is high and busy is low; for a nonzero modulus busy then stays high until the
// result is shown. The result appears on inverse and not_invertible for exactly one
// cycle with done high, and there is no way to hold it off, so the receiver must
// take it then. Each Euclid round runs one serial division plus one check state,
// and the shared divider sets the pace: a request takes at most about 48 rounds
// for 32-bit operands, and a zero modulus is answered without any division. The
// modulus register (address 0) must only be written while busy is low and no
// result is pending.
module modular_inverse_ext_euclid
    import mie_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  start,
    output logic                  busy,
    input  logic [DATA_WIDTH-1:0] value,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] inverse,
    output logic                  not_invertible
);

    state_t                       state_reg, state_next;
    logic [DATA_WIDTH-1:0]        modulus_reg;
    logic [DATA_WIDTH-1:0]        r0_reg, r0_next;
    logic [DATA_WIDTH-1:0]        r1_reg, r1_next;
    logic signed [COEF_WIDTH-1:0] s0_reg, s0_next;
    logic signed [COEF_WIDTH-1:0] s1_reg, s1_next;
    logic                         neg_reg, neg_next;
    logic [DATA_WIDTH-1:0]        red_reg, red_next;
    logic [DATA_WIDTH-1:0]        inverse_reg, inverse_next;
    logic                         not_inv_reg, not_inv_next;
    logic                         done_reg, done_next;
    logic                         div_go;

    div_stat_t                    div_stat;
    logic [DATA_WIDTH-1:0]        div_rem;
    logic signed [COEF_WIDTH-1:0] div_prod;

    logic [COEF_WIDTH-1:0]        mag;
    logic [COEF_WIDTH-1:0]        mag_sub;
    logic                         cfg_write;

    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_MODULUS) ? 32'(modulus_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MODULUS_RESET;
        end
        else if (cfg_write && (paddr[2] == REG_MODULUS))
        begin
            modulus_reg <= pwdata[DATA_WIDTH-1:0];
        end
    end

    mie_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go),
        .dividend (r0_reg),
        .divisor  (r1_reg),
        .mult     (s1_reg),
        .stat     (div_stat),
        .rem      (div_rem),
        .prod     (div_prod)
    );

    always_comb
    begin
        state_next   = state_reg;
        r0_next      = r0_reg;
        r1_next      = r1_reg;
        s0_next      = s0_reg;
        s1_next      = s1_reg;
        neg_next     = neg_reg;
        red_next     = red_reg;
        inverse_next = inverse_reg;
        not_inv_next = not_inv_reg;
        done_next    = 1'b0;
        div_go       = 1'b0;

        mag     = s0_reg[COEF_WIDTH-1] ? COEF_WIDTH'(-s0_reg) : COEF_WIDTH'(s0_reg);
        mag_sub = mag - {2'b00, modulus_reg};

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (modulus_reg == '0)
                    begin
                        // A zero modulus has no inverse at all.
                        inverse_next = '0;
                        not_inv_next = 1'b1;
                        done_next    = 1'b1;
                    end
                    else
                    begin
                        r0_next    = value;
                        r1_next    = modulus_reg;
                        s0_next    = COEF_WIDTH'(1);
                        s1_next    = '0;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (r1_reg == '0)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    div_go     = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    r0_next    = r1_reg;
                    r1_next    = div_rem;
                    s0_next    = s1_reg;
                    s1_next    = s0_reg - div_prod;
                    state_next = ST_CHECK;
                end
            end
            ST_FIN:
            begin
                // The magnitude never exceeds the modulus, so one subtract reduces it.
                neg_next   = s0_reg[COEF_WIDTH-1];
                red_next   = mag_sub[COEF_WIDTH-1] ? mag[DATA_WIDTH-1:0]
                                                   : mag_sub[DATA_WIDTH-1:0];
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                inverse_next = (neg_reg && (red_reg != '0)) ? (modulus_reg - red_reg)
                                                            : red_reg;
                not_inv_next = (r0_reg != DATA_WIDTH'(1));
                done_next    = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r0_reg      <= r0_next;
        r1_reg      <= r1_next;
        s0_reg      <= s0_next;
        s1_reg      <= s1_next;
        neg_reg     <= neg_next;
        red_reg     <= red_next;
        inverse_reg <= inverse_next;
        not_inv_reg <= not_inv_next;
    end

    assign busy           = (state_reg != ST_IDLE);
    assign done           = done_reg;
    assign inverse        = inverse_reg;
    assign not_invertible = not_inv_reg;

    // The divider only runs while a request is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> !div_stat.busy)
        else $error("divider active while the block is idle");

    // A finished division leaves a remainder below the divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && div_stat.done) |-> (div_rem < r1_reg))
        else $error("division remainder not below divisor");

    // A zero modulus answers on the next cycle with the flag set.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && modulus_reg == '0) |=>
            (done && not_invertible && inverse == '0))
        else $error("zero modulus not answered at once");

    // Every delivered inverse lies below a nonzero modulus.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && modulus_reg != '0) |-> (inverse < modulus_reg))
        else $error("inverse not reduced below the modulus");

endmodule
